>>> rtl/core/sbc_pkg.sv
// Package for the SHA-256 block compressor: shared types, constants and
// the round functions. Used by every module of the block; depends on nothing.
`default_nettype none

package sbc_pkg;

  localparam int unsigned WordWidth  = 32;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned NumRounds  = 64;
  localparam int unsigned HashWords  = 8;
  localparam int unsigned QueueDepthDefault = 4;

  // One message word as it travels from the front to the back.
  typedef struct packed {
    logic [WordWidth-1:0] word;
    logic                 fresh;  // first word of a block that restarts the hash
    logic                 last;   // sixteenth word of the final block
  } entry_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } back_state_e;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  // Standard initial hash values.
  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0:    v = 32'h6a09e667;
      3'd1:    v = 32'hbb67ae85;
      3'd2:    v = 32'h3c6ef372;
      3'd3:    v = 32'ha54ff53a;
      3'd4:    v = 32'h510e527f;
      3'd5:    v = 32'h9b05688c;
      3'd6:    v = 32'h1f83d9ab;
      default: v = 32'h5be0cd19;
    endcase
    iv_word = v;
  endfunction

  // Round constants.
  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  default: k = 32'hc67178f2;
    endcase
    round_k = k;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/sbc_front.sv
// Front end of the SHA-256 block compressor: accepts message words, tracks
// the word position inside the block and tags block start and final flags.
// Depends on sbc_pkg.
`default_nettype none

module sbc_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [31:0]    message_word_i,
  input  wire logic           new_message_i,
  input  wire logic           final_block_i,
  output logic                push_o,
  output sbc_pkg::entry_t     push_entry_o,
  input  wire logic           queue_full_i
);

  logic [3:0] word_pos_q, word_pos_d;
  logic       accept;

  // A word is taken whenever the queue has room.
  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;

  // The restart flag counts only on a first word, the final flag only on a
  // sixteenth word.
  always_comb begin
    push_entry_o.word  = message_word_i;
    push_entry_o.fresh = new_message_i && (word_pos_q == 4'd0);
    push_entry_o.last  = final_block_i && (word_pos_q == 4'(sbc_pkg::BlockWords - 1));
  end

  // Position counter wraps after sixteen words.
  assign word_pos_d = accept ? word_pos_q + 4'd1 : word_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_pos_q <= 4'd0;
    end else begin
      word_pos_q <= word_pos_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sbc_fifo.sv
// Short word queue between the front and back ends of the compressor.
// Depends on sbc_pkg for the entry type.
`default_nettype none

module sbc_fifo #(
  parameter int unsigned Depth = sbc_pkg::QueueDepthDefault
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  sbc_pkg::entry_t     push_entry_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output sbc_pkg::entry_t     pop_entry_o
);

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);

  sbc_pkg::entry_t       mem_q [Depth];
  logic [PtrWidth-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntWidth-1:0]   count_q;

  assign full_o      = (count_q == CntWidth'(Depth));
  assign valid_o     = (count_q != '0);
  assign pop_entry_o = mem_q[rd_ptr_q];

  // Storage has no reset; only written entries are ever read.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  // Pointers wrap at the depth, which need not be a power of two.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue read while empty");

endmodule

`default_nettype wire

>>> rtl/core/sbc_back.sv
// Back end of the SHA-256 block compressor: one round per cycle while words
// are queued for the load rounds, rolling schedule window, chaining value
// feed-forward and digest output register. Depends on sbc_pkg.
`default_nettype none

module sbc_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_valid_i,
  input  sbc_pkg::entry_t     q_entry_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [31:0]         digest_word_o,
  output logic [2:0]          digest_index_o,
  output logic                digest_last_o
);

  localparam int unsigned HW = sbc_pkg::HashWords;

  sbc_pkg::back_state_e state_q, state_d;

  logic [31:0] cv_q  [HW];
  logic [31:0] wv_q  [HW];
  logic [31:0] win_q [sbc_pkg::BlockWords];
  logic [5:0]  rnd_q;
  logic        final_q;
  logic [2:0]  emit_idx_q;

  logic        out_valid_q;
  logic [31:0] out_word_q;
  logic [2:0]  out_idx_q;

  logic        advance;
  logic        load_phase;
  logic        emit_load;

  logic [31:0] base_cv  [HW];
  logic [31:0] cur      [HW];
  logic [31:0] nxt      [HW];
  logic [31:0] w_exp, w_cur, t1, t2;

  assign load_phase = (rnd_q < 6'(sbc_pkg::BlockWords));

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sbc_pkg::ST_ROUND: begin
        if (advance && rnd_q == 6'(sbc_pkg::NumRounds - 1)) begin
          state_d = sbc_pkg::ST_ADD;
        end
      end
      sbc_pkg::ST_ADD: begin
        state_d = final_q ? sbc_pkg::ST_EMIT : sbc_pkg::ST_ROUND;
      end
      sbc_pkg::ST_EMIT: begin
        if (emit_load && emit_idx_q == 3'(HW - 1)) begin
          state_d = sbc_pkg::ST_ROUND;
        end
      end
      default: state_d = sbc_pkg::ST_ROUND;
    endcase
  end

  // Sequencer outputs: rounds in the load phase wait for a queued word.
  always_comb begin
    q_pop_o   = 1'b0;
    advance   = 1'b0;
    emit_load = 1'b0;
    unique case (state_q)
      sbc_pkg::ST_ROUND: begin
        q_pop_o = load_phase && q_valid_i;
        advance = !load_phase || q_valid_i;
      end
      sbc_pkg::ST_EMIT: begin
        emit_load = !out_valid_q || out_ready_i;
      end
      default: ;
    endcase
  end

  // Round datapath. Round zero starts from the chaining value, or from the
  // initial hash when the block restarts the message.
  always_comb begin
    for (int i = 0; i < HW; i++) begin
      base_cv[i] = q_entry_i.fresh ? sbc_pkg::iv_word(3'(i)) : cv_q[i];
      cur[i]     = (rnd_q == 6'd0) ? base_cv[i] : wv_q[i];
    end
    w_exp = sbc_pkg::small_sigma1(win_q[14]) + win_q[9]
          + sbc_pkg::small_sigma0(win_q[1]) + win_q[0];
    w_cur = load_phase ? q_entry_i.word : w_exp;
    t1 = cur[7] + sbc_pkg::big_sigma1(cur[4])
       + ((cur[4] & cur[5]) ^ (~cur[4] & cur[6]))
       + sbc_pkg::round_k(rnd_q) + w_cur;
    t2 = sbc_pkg::big_sigma0(cur[0])
       + ((cur[0] & cur[1]) ^ (cur[0] & cur[2]) ^ (cur[1] & cur[2]));
    nxt[0] = t1 + t2;
    nxt[1] = cur[0];
    nxt[2] = cur[1];
    nxt[3] = cur[2];
    nxt[4] = cur[3] + t1;
    nxt[5] = cur[4];
    nxt[6] = cur[5];
    nxt[7] = cur[6];
  end

  // Working variables, schedule window and output data register carry no reset.
  always_ff @(posedge clk_i) begin
    if (state_q == sbc_pkg::ST_ROUND && advance) begin
      for (int i = 0; i < HW; i++) begin
        wv_q[i] <= nxt[i];
      end
      for (int i = 0; i < sbc_pkg::BlockWords - 1; i++) begin
        win_q[i] <= win_q[i + 1];
      end
      win_q[sbc_pkg::BlockWords - 1] <= w_cur;
    end
    if (emit_load) begin
      out_word_q <= cv_q[emit_idx_q];
      out_idx_q  <= emit_idx_q;
    end
  end

  // Control state and chaining value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sbc_pkg::ST_ROUND;
      rnd_q       <= 6'd0;
      final_q     <= 1'b0;
      emit_idx_q  <= 3'd0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < HW; i++) begin
        cv_q[i] <= sbc_pkg::iv_word(3'(i));
      end
    end else begin
      state_q <= state_d;
      if (state_q == sbc_pkg::ST_ROUND && advance) begin
        rnd_q <= rnd_q + 6'd1;
      end
      if (q_pop_o && rnd_q == 6'd0) begin
        for (int i = 0; i < HW; i++) begin
          cv_q[i] <= base_cv[i];
        end
      end
      if (q_pop_o && rnd_q == 6'(sbc_pkg::BlockWords - 1)) begin
        final_q <= q_entry_i.last;
      end
      if (state_q == sbc_pkg::ST_ADD) begin
        for (int i = 0; i < HW; i++) begin
          cv_q[i] <= cv_q[i] + wv_q[i];
        end
      end
      if (emit_load) begin
        emit_idx_q  <= emit_idx_q + 3'd1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign digest_word_o  = out_word_q;
  assign digest_index_o = out_idx_q;
  assign digest_last_o  = (out_idx_q == 3'(HW - 1));

  a_pop_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> load_phase) else $error("word taken outside the load rounds");
  a_add_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sbc_pkg::ST_ADD) |=> (rnd_q == 6'd0 && emit_idx_q == 3'd0))
    else $error("round or digest counter misaligned after a block");
  a_emit_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sbc_pkg::ST_EMIT) |-> final_q)
    else $error("digest sent for a block that was not final");

endmodule

`default_nettype wire

>>> rtl/core/sha256_block_compressor_top.sv
// SHA-256 block compressor, top level.
// Usage: padded message words enter on the in channel (valid/ready), one
// big-endian 32-bit word per transfer; sixteen words form a block. Raise
// new_message_i on a block's first word to restart from the initial hash,
// and final_block_i on the sixteenth word of the last block.
// After a final block the eight digest words leave on the out channel, index
// 0 first, with digest_last_o on index 7.
// Timing: words go into a short queue, so the in channel takes words while
// the compression engine runs, until the queue is full. The engine does one
// round per cycle: 16 rounds paced by the arriving words, 48 further rounds,
// then a feed-forward step. After that a final block sends the eight digest
// words, slower if the receiver stalls; while stalled the output register
// holds its word and the engine waits. The first digest word is loaded into
// the output register in the emit state that follows a final block's add.
// Reset loads the initial hash as chaining value and clears all counters.
// Depends on sbc_pkg, sbc_front, sbc_fifo and sbc_back.
`default_nettype none

module sha256_block_compressor_top #(
  parameter int unsigned QueueDepth = sbc_pkg::QueueDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] message_word_i,
  input  wire logic        new_message_i,
  input  wire logic        final_block_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       digest_index_o,
  output logic             digest_last_o
);

  logic            push;
  logic            full;
  logic            pop;
  logic            q_valid;
  sbc_pkg::entry_t push_entry;
  sbc_pkg::entry_t pop_entry;

  // Word loader and classifier.
  sbc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .message_word_i (message_word_i),
    .new_message_i  (new_message_i),
    .final_block_i  (final_block_i),
    .push_o         (push),
    .push_entry_o   (push_entry),
    .queue_full_i   (full)
  );

  // Queue between loader and engine.
  sbc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .valid_o      (q_valid),
    .pop_entry_o  (pop_entry)
  );

  // Compression engine and digest output.
  sbc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_entry_i      (pop_entry),
    .q_pop_o        (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .digest_word_o  (digest_word_o),
    .digest_index_o (digest_index_o),
    .digest_last_o  (digest_last_o)
  );

endmodule

`default_nettype wire
